// File: sv/wrp_pkg.sv
// ----------------------------------------------------------------------------
// wrp_pkg
// shared beat types, status codes and tag constants for the wave header parser
// ----------------------------------------------------------------------------
package wrp_pkg;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_RIFF = 2'd1;
    localparam logic [1:0] ST_BAD_WAVE = 2'd2;
    localparam logic [1:0] ST_NO_DATA  = 2'd3;

    // four-character tags as little endian words
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // format tags that carry the full field set
    localparam logic [15:0] FMT_PCM = 16'h0001;
    localparam logic [15:0] FMT_EXT = 16'hFFFE;

    // riff size counts from the end of the size field
    localparam logic [33:0] RIFF_HDR_BYTES = 34'd8;
    localparam logic [32:0] OFF_MAX        = 33'h1_FFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] riff_size;
        logic [15:0] audio_format;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] data_size;
        logic [32:0] data_offset;
    } t_out_beat;

endpackage

// File: sv/wrp_in_reg.sv
// ----------------------------------------------------------------------------
// wrp_in_reg
// input register: holds one header byte beat until the parser takes it
// ----------------------------------------------------------------------------
module wrp_in_reg
    import wrp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_beat i_beat,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_beat o_beat
);

    logic     r_valid;
    logic     n_valid;
    t_in_beat r_beat;
    logic     accept;

    assign o_stall = r_valid && !i_take;
    assign accept  = i_valid && !o_stall;
    assign n_valid = accept || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// File: sv/wrp_parse_core.sv
// ----------------------------------------------------------------------------
// wrp_parse_core
// parse state and the per-byte update; flags a result on the deciding byte
// ----------------------------------------------------------------------------
module wrp_parse_core
    import wrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_beat  i_beat,
    output logic      o_res_valid,
    output t_out_beat o_res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RIFF_TAG, PH_RIFF_SIZE, PH_WAVE_TAG, PH_CHUNK_ID, PH_CHUNK_SZ,
        PH_FMT_FMT, PH_FMT_CHAN, PH_FMT_RATE, PH_FMT_BRATE, PH_FMT_ALIGN,
        PH_FMT_BITS, PH_SKIP, PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase, cur_phase;
    logic [1:0]  r_idx, n_idx, cur_idx;
    logic [32:0] r_off, n_off, cur_off;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_acc, n_acc, cur_acc;
    logic [31:0] r_riff, n_riff;
    logic [15:0] r_fmt, n_fmt;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_brate, n_brate;
    logic [15:0] r_align, n_align;
    logic [15:0] r_bits, n_bits;

    logic        first;
    logic        active;
    logic        done2, done4;
    logic        do_end;
    logic        emit;
    logic [1:0]  emit_status;
    logic [31:0] emit_size;
    logic [32:0] emit_off;
    logic [31:0] rem_dec;

    assign first     = i_beat.first_byte;
    assign active    = i_step && (first || (r_phase != PH_IDLE && r_phase != PH_DONE));
    assign cur_phase = first ? PH_RIFF_TAG : r_phase;
    assign cur_idx   = first ? 2'd0 : r_idx;
    assign cur_off   = first ? 33'd0 : r_off;
    assign cur_acc   = first ? 32'd0 : r_acc;
    assign done2     = (cur_idx == 2'd1);
    assign done4     = (cur_idx == 2'd3);
    assign rem_dec   = r_rem - 32'd1;

    always_comb begin
        n_phase     = r_phase;
        n_idx       = r_idx;
        n_off       = r_off;
        n_rem       = first ? 32'd0 : r_rem;
        n_tag       = first ? 32'd0 : r_tag;
        n_acc       = r_acc;
        n_riff      = first ? 32'd0 : r_riff;
        n_fmt       = first ? 16'd0 : r_fmt;
        n_chan      = first ? 16'd0 : r_chan;
        n_rate      = first ? 32'd0 : r_rate;
        n_brate     = first ? 32'd0 : r_brate;
        n_align     = first ? 16'd0 : r_align;
        n_bits      = first ? 16'd0 : r_bits;
        do_end      = 1'b0;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_size   = 32'd0;
        emit_off    = 33'd0;

        if (active) begin
            n_phase = cur_phase;
            n_off   = (cur_off == OFF_MAX) ? cur_off : cur_off + 33'd1;
            n_idx   = cur_idx + 2'd1;
            case (cur_idx)
                2'd0:    n_acc = {24'd0, i_beat.data_byte};
                2'd1:    n_acc = {cur_acc[31:16], i_beat.data_byte, cur_acc[7:0]};
                2'd2:    n_acc = {cur_acc[31:24], i_beat.data_byte, cur_acc[15:0]};
                default: n_acc = {i_beat.data_byte, cur_acc[23:0]};
            endcase

            case (cur_phase)
                PH_RIFF_TAG: begin
                    if (done4) begin
                        if (n_acc != TAG_RIFF) begin
                            emit        = 1'b1;
                            emit_status = ST_BAD_RIFF;
                        end else begin
                            n_phase = PH_RIFF_SIZE;
                        end
                    end
                end
                PH_RIFF_SIZE: begin
                    if (done4) begin
                        n_riff  = n_acc;
                        n_phase = PH_WAVE_TAG;
                    end
                end
                PH_WAVE_TAG: begin
                    if (done4) begin
                        if (n_acc != TAG_WAVE) begin
                            emit        = 1'b1;
                            emit_status = ST_BAD_WAVE;
                        end else begin
                            n_phase = PH_CHUNK_ID;
                        end
                    end
                end
                PH_CHUNK_ID: begin
                    if (done4) begin
                        n_tag   = n_acc;
                        n_phase = PH_CHUNK_SZ;
                    end
                end
                PH_CHUNK_SZ: begin
                    if (done4) begin
                        if (r_tag == TAG_DATA) begin
                            emit      = 1'b1;
                            emit_size = n_acc;
                            emit_off  = n_off;
                        end else begin
                            n_rem = n_acc;
                            if (n_acc == 32'd0) begin
                                do_end = 1'b1;
                            end else if (r_tag == TAG_FMT) begin
                                n_phase = PH_FMT_FMT;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                end
                PH_FMT_FMT, PH_FMT_CHAN, PH_FMT_RATE, PH_FMT_BRATE,
                PH_FMT_ALIGN, PH_FMT_BITS, PH_SKIP: begin
                    // chunk body, remaining count is nonzero here
                    n_rem = rem_dec;
                    case (cur_phase)
                        PH_FMT_FMT: begin
                            if (done2) begin
                                n_fmt = n_acc[15:0];
                                n_idx = 2'd0;
                                if (n_acc[15:0] == FMT_PCM || n_acc[15:0] == FMT_EXT) begin
                                    n_phase = PH_FMT_CHAN;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                        PH_FMT_CHAN: begin
                            if (done2) begin
                                n_chan  = n_acc[15:0];
                                n_idx   = 2'd0;
                                n_phase = PH_FMT_RATE;
                            end
                        end
                        PH_FMT_RATE: begin
                            if (done4) begin
                                n_rate  = n_acc;
                                n_phase = PH_FMT_BRATE;
                            end
                        end
                        PH_FMT_BRATE: begin
                            if (done4) begin
                                n_brate = n_acc;
                                n_phase = PH_FMT_ALIGN;
                            end
                        end
                        PH_FMT_ALIGN: begin
                            if (done2) begin
                                n_align = n_acc[15:0];
                                n_idx   = 2'd0;
                                n_phase = PH_FMT_BITS;
                            end
                        end
                        PH_FMT_BITS: begin
                            if (done2) begin
                                n_bits  = n_acc[15:0];
                                n_idx   = 2'd0;
                                n_phase = PH_SKIP;
                            end
                        end
                        default: begin
                            n_idx = 2'd0;
                        end
                    endcase
                    if (rem_dec == 32'd0) begin
                        do_end = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            // chunk end: stop at the riff end, else look for the next chunk
            if (do_end) begin
                n_idx = 2'd0;
                if ({1'b0, n_off} >= {2'b00, n_riff} + RIFF_HDR_BYTES) begin
                    emit        = 1'b1;
                    emit_status = ST_NO_DATA;
                end else begin
                    n_phase = PH_CHUNK_ID;
                end
            end

            if (emit) begin
                n_phase = PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= 2'd0;
            r_off   <= 33'd0;
            r_rem   <= 32'd0;
            r_tag   <= 32'd0;
            r_acc   <= 32'd0;
            r_riff  <= 32'd0;
            r_fmt   <= 16'd0;
            r_chan  <= 16'd0;
            r_rate  <= 32'd0;
            r_brate <= 32'd0;
            r_align <= 16'd0;
            r_bits  <= 16'd0;
        end else if (active) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_off   <= n_off;
            r_rem   <= n_rem;
            r_tag   <= n_tag;
            r_acc   <= n_acc;
            r_riff  <= n_riff;
            r_fmt   <= n_fmt;
            r_chan  <= n_chan;
            r_rate  <= n_rate;
            r_brate <= n_brate;
            r_align <= n_align;
            r_bits  <= n_bits;
        end
    end

    assign o_res_valid         = emit;
    assign o_res.status        = emit_status;
    assign o_res.riff_size     = n_riff;
    assign o_res.audio_format  = n_fmt;
    assign o_res.channel_count = n_chan;
    assign o_res.sample_rate   = n_rate;
    assign o_res.byte_rate     = n_brate;
    assign o_res.block_align   = n_align;
    assign o_res.sample_bits   = n_bits;
    assign o_res.data_size     = emit_size;
    assign o_res.data_offset   = emit_off;

endmodule

// File: sv/wrp_out_reg.sv
// ----------------------------------------------------------------------------
// wrp_out_reg
// result register: holds one result beat until the sink takes it
// ----------------------------------------------------------------------------
module wrp_out_reg
    import wrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_beat i_beat,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_beat
);

    logic      r_valid;
    logic      n_valid;
    t_out_beat r_beat;

    assign o_room  = !r_valid || !i_stall;
    assign n_valid = i_load || (r_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// File: sv/wav_riff_header_parser.sv
// ----------------------------------------------------------------------------
// wav_riff_header_parser
// walks a riff/wave header one byte beat at a time and reports the format
// ----------------------------------------------------------------------------
// throughput: one header byte beat per cycle, sustained while the result register has room
// result path: the deciding byte passes the input register, then the parse step
//   loads the result register, which drives o_out_valid; a full one stalls the byte
// the per-byte parse step between the two registers sets the byte rate
// reset: synchronous active low; parser waits for a first-byte beat, both
//   registers come up empty
module wav_riff_header_parser
    import wrp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // header byte channel
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    // result channel
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic      in_valid;
    t_in_beat  in_beat;
    logic      out_room;
    logic      take;
    logic      res_valid;
    t_out_beat res_beat;

    // byte moves from the input register into the parser only when the
    // result register can take whatever that byte decides
    assign take = in_valid && out_room;

    // input register, lets a new byte land while a result waits
    wrp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_beat  (i_in_data),
        .i_take  (take),
        .o_valid (in_valid),
        .o_beat  (in_beat)
    );

    // parse state and per-byte update
    wrp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (take),
        .i_beat      (in_beat),
        .o_res_valid (res_valid),
        .o_res       (res_beat)
    );

    // result register, at most one result per header
    wrp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res_valid),
        .i_beat  (res_beat),
        .o_room  (out_room),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_beat  (o_out_data)
    );

endmodule
